// File: rtl/cascadable_prescaled_timers_defines.svh
// Assertion macros shared by the checker of the prescaled timer block.
// No dependencies; take in with `include before use.
`ifndef CASCADABLE_PRESCALED_TIMERS_DEFINES_SVH
`define CASCADABLE_PRESCALED_TIMERS_DEFINES_SVH

// same-cycle implication, off while reset is held
`define CPT_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("cpt assertion failed");

// next-cycle implication, off while reset is held
`define CPT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("cpt assertion failed");

// next-cycle implication, active during reset as well
`define CPT_ASSERT_ALWAYS_NEXT(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("cpt assertion failed");

`endif

// File: rtl/cpt_pkg.sv
// Shared types, widths, register indexes and default rates for the
// prescaled timer block. No dependencies.
`default_nettype none

package cpt_pkg;

    localparam int NUM_TIMERS = 4;
    localparam int ACC_W      = 32;
    localparam int CNT_W      = 8;
    localparam int LINE_W     = 16;
    localparam int TICK_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int SEL_W      = 2;

    localparam int DEF_LINE_TICKS     = 515;
    localparam int DEF_RATE_BASE      = 8;
    localparam int DEF_RATE_QUARTER   = 32;
    localparam int DEF_RATE_SIXTEENTH = 128;
    localparam int DEF_RATE_SLOWEST   = 2048;

    typedef logic [ACC_W-1:0]  t_accum;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [LINE_W-1:0] t_line;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_MASK    = 3'd0,
        CFG_MODE_PAIR_A = 3'd1,
        CFG_MODE_PAIR_B = 3'd2,
        CFG_LIMIT_ZERO  = 3'd3,
        CFG_LIMIT_ONE   = 3'd4,
        CFG_LIMIT_TWO   = 3'd5,
        CFG_LIMIT_THREE = 3'd6
    } t_cfg_index;

    typedef enum logic [SEL_W-1:0] {
        SEL_PULSE  = 2'd0,
        SEL_RATE_A = 2'd1,
        SEL_RATE_B = 2'd2,
        SEL_RATE_C = 2'd3
    } t_clk_sel;

    typedef struct packed {
        logic     run;
        t_clk_sel sel;
        t_count   limit;
        logic     pulse;
    } t_timer_ctrl;

    typedef struct packed {
        logic match;
        logic pulse_used;
    } t_timer_stat;

endpackage

`default_nettype wire

// File: rtl/cascadable_prescaled_timers.sv
// Top level of the cascadable prescaled timer block: input stage, line
// accumulator, four timer units and the result register.
// Depends on cpt_pkg and cpt_timer_unit.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one slice of CPU ticks
//   and the h-blank flag per transfer. Output channel (o_out_valid /
//   i_out_ready) returns exactly one result per slice: line_end and the
//   four match pulses, in order.
//   Config channel (i_cfg_valid / o_cfg_ready) is always ready and writes
//   register i_cfg_index with i_cfg_data; index 7 is ignored. Write only
//   while no slice is in flight.
//   Path: the input register, then the result register. Throughput: one slice
//   per cycle while the receiver takes results; the combinational timer chain
//   (counter 0 into 1, counter 2 into 3) sets that figure.
//   Rates must be powers of two.
//   Reset (synchronous, active low) clears all counters, prescalers, the
//   line accumulator, the config registers and the valid bits of both stages.
//   Receiver stall: the result register holds; the input register takes one
//   more slice, then o_in_ready drops until the result is taken.
`default_nettype none

module cascadable_prescaled_timers
    import cpt_pkg::*;
#(
    parameter int LINE_TICKS     = DEF_LINE_TICKS,
    parameter int RATE_BASE      = DEF_RATE_BASE,
    parameter int RATE_QUARTER   = DEF_RATE_QUARTER,
    parameter int RATE_SIXTEENTH = DEF_RATE_SIXTEENTH,
    parameter int RATE_SLOWEST   = DEF_RATE_SLOWEST
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [TICK_W-1:0]     i_ticks,
    input  logic                  i_hblank_flag,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_line_end,
    output logic                  o_match_zero,
    output logic                  o_match_one,
    output logic                  o_match_two,
    output logic                  o_match_three,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SH_BASE      = $clog2(RATE_BASE);
    localparam int SH_HALF      = SH_BASE - 1;
    localparam int SH_QUARTER   = $clog2(RATE_QUARTER);
    localparam int SH_SIXTEENTH = $clog2(RATE_SIXTEENTH);
    localparam int SH_SLOWEST   = $clog2(RATE_SLOWEST);
    localparam t_line LINE_LEN  = t_line'(LINE_TICKS);

    logic [NUM_TIMERS-1:0] r_run_mask;
    t_clk_sel              r_sel [NUM_TIMERS];
    t_count                r_limit [NUM_TIMERS];

    logic               r_in_valid;
    logic [TICK_W-1:0]  r_ticks;
    logic               r_hblank;

    t_line  r_line_accum, n_line_accum;
    logic   r_hblank_latch, n_hblank_latch;
    t_accum r_accum [NUM_TIMERS];
    t_count r_count [NUM_TIMERS];

    logic r_out_valid;
    logic r_line_end;
    logic [NUM_TIMERS-1:0] r_match;

    logic        w_advance;
    logic        w_cfg_write;
    logic [LINE_W:0] w_line_sum;
    t_line       w_line_sat;
    logic        w_line;
    logic        w_latch_mid;
    t_accum      w_acc_add [NUM_TIMERS];
    t_accum      n_accum [NUM_TIMERS];
    t_count      n_count [NUM_TIMERS];
    t_timer_ctrl w_ctrl [NUM_TIMERS];
    t_timer_stat w_stat [NUM_TIMERS];

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid;

    // line boundary
    always_comb begin
        w_line_sum   = {1'b0, r_line_accum} + (LINE_W + 1)'(r_ticks);
        w_line_sat   = w_line_sum[LINE_W] ? '1 : w_line_sum[LINE_W-1:0];
        w_line       = (w_line_sat >= LINE_LEN);
        n_line_accum = w_line ? (w_line_sat - LINE_LEN) : w_line_sat;
        w_latch_mid  = w_line ? r_hblank : r_hblank_latch;
    end

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            w_acc_add[i]    = r_accum[i] + t_accum'(r_ticks);
            w_ctrl[i].run   = r_run_mask[i];
            w_ctrl[i].sel   = r_sel[i];
            w_ctrl[i].limit = r_limit[i];
        end
        w_ctrl[0].pulse = w_latch_mid;
        w_ctrl[1].pulse = w_stat[0].match;
        w_ctrl[2].pulse = 1'b0;
        w_ctrl[3].pulse = w_stat[2].match;
        n_hblank_latch  = w_latch_mid && !w_stat[0].pulse_used;
    end

    cpt_timer_unit #(
        .SHIFT_A(SH_BASE), .SHIFT_B(SH_QUARTER), .SHIFT_C(SH_SIXTEENTH)
    ) u_timer_zero (
        .i_accum(w_acc_add[0]), .i_count(r_count[0]), .i_ctrl(w_ctrl[0]),
        .o_accum(n_accum[0]), .o_count(n_count[0]), .o_stat(w_stat[0])
    );

    cpt_timer_unit #(
        .SHIFT_A(SH_BASE), .SHIFT_B(SH_SIXTEENTH), .SHIFT_C(SH_SLOWEST)
    ) u_timer_one (
        .i_accum(w_acc_add[1]), .i_count(r_count[1]), .i_ctrl(w_ctrl[1]),
        .o_accum(n_accum[1]), .o_count(n_count[1]), .o_stat(w_stat[1])
    );

    cpt_timer_unit #(
        .SHIFT_A(SH_HALF), .SHIFT_B(SH_QUARTER), .SHIFT_C(SH_SIXTEENTH)
    ) u_timer_two (
        .i_accum(w_acc_add[2]), .i_count(r_count[2]), .i_ctrl(w_ctrl[2]),
        .o_accum(n_accum[2]), .o_count(n_count[2]), .o_stat(w_stat[2])
    );

    cpt_timer_unit #(
        .SHIFT_A(SH_BASE), .SHIFT_B(SH_SIXTEENTH), .SHIFT_C(SH_SLOWEST)
    ) u_timer_three (
        .i_accum(w_acc_add[3]), .i_count(r_count[3]), .i_ctrl(w_ctrl[3]),
        .o_accum(n_accum[3]), .o_count(n_count[3]), .o_stat(w_stat[3])
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_mask <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_sel[i]   <= SEL_PULSE;
                r_limit[i] <= '0;
            end
        end else if (w_cfg_write) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_RUN_MASK:    r_run_mask <= i_cfg_data[NUM_TIMERS-1:0];
                CFG_MODE_PAIR_A: begin
                    r_sel[0] <= t_clk_sel'(i_cfg_data[1:0]);
                    r_sel[1] <= t_clk_sel'(i_cfg_data[3:2]);
                end
                CFG_MODE_PAIR_B: begin
                    r_sel[2] <= t_clk_sel'(i_cfg_data[1:0]);
                    r_sel[3] <= t_clk_sel'(i_cfg_data[3:2]);
                end
                CFG_LIMIT_ZERO:  r_limit[0] <= i_cfg_data;
                CFG_LIMIT_ONE:   r_limit[1] <= i_cfg_data;
                CFG_LIMIT_TWO:   r_limit[2] <= i_cfg_data;
                CFG_LIMIT_THREE: r_limit[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ticks  <= i_ticks;
            r_hblank <= i_hblank_flag;
        end
    end

    // timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_accum   <= '0;
            r_hblank_latch <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_accum[i] <= '0;
                r_count[i] <= '0;
            end
        end else if (w_advance) begin
            r_line_accum   <= n_line_accum;
            r_hblank_latch <= n_hblank_latch;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_accum[i] <= n_accum[i];
                r_count[i] <= n_count[i];
            end
        end else if (w_cfg_write && (t_cfg_index'(i_cfg_index) == CFG_RUN_MASK)) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (!i_cfg_data[i]) begin
                    r_count[i] <= '0;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_line_end <= w_line;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_match[i] <= w_stat[i].match;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_end    = r_line_end;
    assign o_match_zero  = r_match[0];
    assign o_match_one   = r_match[1];
    assign o_match_two   = r_match[2];
    assign o_match_three = r_match[3];

endmodule

`default_nettype wire

// File: rtl/cpt_timer_unit.sv
// One 8-bit timer step: prescale reduction, pulse advance and limit match.
// Depends on cpt_pkg. Rates are powers of two, given as shift amounts.
`default_nettype none

module cpt_timer_unit
    import cpt_pkg::*;
#(
    parameter int SHIFT_A = 3,
    parameter int SHIFT_B = 5,
    parameter int SHIFT_C = 7
) (
    input  t_accum      i_accum,
    input  t_count      i_count,
    input  t_timer_ctrl i_ctrl,
    output t_accum      o_accum,
    output t_count      o_count,
    output t_timer_stat o_stat
);

    localparam t_accum MASK_A = t_accum'((64'(1) << SHIFT_A) - 64'(1));
    localparam t_accum MASK_B = t_accum'((64'(1) << SHIFT_B) - 64'(1));
    localparam t_accum MASK_C = t_accum'((64'(1) << SHIFT_C) - 64'(1));

    t_count w_adv;
    logic   w_match;

    always_comb begin
        o_accum           = i_accum;
        w_adv             = i_count;
        o_stat.pulse_used = 1'b0;
        if (i_ctrl.run) begin
            case (i_ctrl.sel)
                SEL_PULSE: begin
                    if (i_ctrl.pulse) begin
                        w_adv             = i_count + t_count'(1);
                        o_accum           = '0;
                        o_stat.pulse_used = 1'b1;
                    end
                end
                SEL_RATE_A: begin
                    w_adv   = i_count + i_accum[SHIFT_A +: CNT_W];
                    o_accum = i_accum & MASK_A;
                end
                SEL_RATE_B: begin
                    w_adv   = i_count + i_accum[SHIFT_B +: CNT_W];
                    o_accum = i_accum & MASK_B;
                end
                default: begin
                    w_adv   = i_count + i_accum[SHIFT_C +: CNT_W];
                    o_accum = i_accum & MASK_C;
                end
            endcase
        end
        w_match      = i_ctrl.run && (i_ctrl.limit != '0) && (w_adv >= i_ctrl.limit);
        o_stat.match = w_match;
        o_count      = w_match ? '0 : w_adv;
    end

endmodule

`default_nettype wire

// File: rtl/cpt_checker.sv
// Port-level checker for the prescaled timer block, bound to the top level.
// Depends on cpt_pkg and cascadable_prescaled_timers_defines.svh.
`default_nettype none
`include "cascadable_prescaled_timers_defines.svh"

module cpt_checker
    import cpt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_line_end,
    input logic o_match_zero,
    input logic o_match_one,
    input logic o_match_two,
    input logic o_match_three
);

    logic [NUM_TIMERS:0] w_payload;

    assign w_payload = {o_line_end, o_match_zero, o_match_one, o_match_two, o_match_three};

    `CPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `CPT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(w_payload))
    `CPT_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)
    `CPT_ASSERT_NOW(a_stall_source, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

endmodule

bind cascadable_prescaled_timers cpt_checker u_cpt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_line_end   (o_line_end),
    .o_match_zero (o_match_zero),
    .o_match_one  (o_match_one),
    .o_match_two  (o_match_two),
    .o_match_three(o_match_three)
);

`default_nettype wire
